// File: rtl/fvp_pkg.sv
package fvp_pkg;

    // default sizes
    localparam int MAX_FIELDS_DEF   = 48;
    localparam int VALUE_BITS_DEF   = 32;

    // port widths
    localparam int FIELD_VALUE_W    = 32;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_INDEX_W      = 3;
    localparam int OFFSET_W         = 8;
    localparam int FIELD_INDEX_W    = 6;
    localparam int BYTE_W           = 8;
    localparam int PEND_W           = 7;
    localparam int PEND_CNT_W       = 3;

    // width table layout
    localparam int TABLE_COUNT      = 4;
    localparam int TABLE_SEL_W      = 2;
    localparam int FIELDS_PER_TABLE = 12;
    localparam int SLOT_W           = 4;
    localparam int WIDTH_CODE_W     = 5;
    localparam int CODE_POS_W       = 6;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VALUE_OFFSET  = 3'd0,
        REG_FIELD_COUNT   = 3'd1,
        REG_WIDTH_TABLE_A = 3'd2,
        REG_WIDTH_TABLE_B = 3'd3,
        REG_WIDTH_TABLE_C = 3'd4,
        REG_WIDTH_TABLE_D = 3'd5
    } cfg_reg_t;

endpackage

// File: rtl/fvp_front.sv
module fvp_front #(
    parameter int MAX_FIELDS = fvp_pkg::MAX_FIELDS_DEF,
    parameter int VALUE_BITS = fvp_pkg::VALUE_BITS_DEF,
    localparam int W_W = $clog2(VALUE_BITS + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fvp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fvp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [fvp_pkg::FIELD_VALUE_W-1:0] field_value,
    output logic                             push_valid,
    input  logic                             push_ready,
    output logic [VALUE_BITS-1:0]            push_value,
    output logic [W_W-1:0]                   push_width,
    output logic                             push_last
);

    localparam int IDX_W = fvp_pkg::FIELD_INDEX_W;

    logic [fvp_pkg::OFFSET_W-1:0]   value_offset_reg;
    logic [IDX_W-1:0]               field_count_reg;
    logic [fvp_pkg::CFG_DATA_W-1:0] width_table_reg [fvp_pkg::TABLE_COUNT];
    logic [IDX_W-1:0]               field_index_reg;
    logic [IDX_W-1:0]               field_index_next;

    logic [IDX_W-1:0]                    rec_len;
    logic                                last_field;
    logic [IDX_W-1:0]                    idx;
    logic [fvp_pkg::TABLE_SEL_W-1:0]     tab_sel;
    logic [IDX_W-1:0]                    tab_base;
    logic [fvp_pkg::SLOT_W-1:0]          slot;
    logic [fvp_pkg::CODE_POS_W-1:0]      code_pos;
    logic [fvp_pkg::CFG_DATA_W-1:0]      tab_word;
    logic [fvp_pkg::WIDTH_CODE_W-1:0]    width_code;
    logic [fvp_pkg::CODE_POS_W-1:0]      width_sum;
    logic [fvp_pkg::CODE_POS_W-1:0]      width_sat;
    logic [VALUE_BITS-1:0]               diff;
    logic [VALUE_BITS-1:0]               value_mask;
    logic                                push;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_offset_reg <= fvp_pkg::OFFSET_W'(1);
            field_count_reg  <= IDX_W'(1);
            for (int i = 0; i < fvp_pkg::TABLE_COUNT; i++)
            begin
                width_table_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (fvp_pkg::cfg_reg_t'(cfg_index))
                fvp_pkg::REG_VALUE_OFFSET:  value_offset_reg   <= cfg_data[fvp_pkg::OFFSET_W-1:0];
                fvp_pkg::REG_FIELD_COUNT:   field_count_reg    <= cfg_data[IDX_W-1:0];
                fvp_pkg::REG_WIDTH_TABLE_A: width_table_reg[0] <= cfg_data;
                fvp_pkg::REG_WIDTH_TABLE_B: width_table_reg[1] <= cfg_data;
                fvp_pkg::REG_WIDTH_TABLE_C: width_table_reg[2] <= cfg_data;
                fvp_pkg::REG_WIDTH_TABLE_D: width_table_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // record length and last-field classification
    always_comb
    begin
        if (field_count_reg == '0)
            rec_len = IDX_W'(1);
        else if (field_count_reg > IDX_W'(MAX_FIELDS))
            rec_len = IDX_W'(MAX_FIELDS);
        else
            rec_len = field_count_reg;
        last_field = (field_index_reg >= rec_len - IDX_W'(1));
        idx        = last_field ? rec_len - IDX_W'(1) : field_index_reg;
    end

    // width lookup: pick the table, then the slot's five-bit width code
    always_comb
    begin
        if (idx < IDX_W'(fvp_pkg::FIELDS_PER_TABLE))
        begin
            tab_sel  = fvp_pkg::TABLE_SEL_W'(0);
            tab_base = '0;
        end
        else if (idx < IDX_W'(2 * fvp_pkg::FIELDS_PER_TABLE))
        begin
            tab_sel  = fvp_pkg::TABLE_SEL_W'(1);
            tab_base = IDX_W'(fvp_pkg::FIELDS_PER_TABLE);
        end
        else if (idx < IDX_W'(3 * fvp_pkg::FIELDS_PER_TABLE))
        begin
            tab_sel  = fvp_pkg::TABLE_SEL_W'(2);
            tab_base = IDX_W'(2 * fvp_pkg::FIELDS_PER_TABLE);
        end
        else
        begin
            tab_sel  = fvp_pkg::TABLE_SEL_W'(3);
            tab_base = IDX_W'(3 * fvp_pkg::FIELDS_PER_TABLE);
        end
        slot       = fvp_pkg::SLOT_W'(idx - tab_base);
        code_pos   = fvp_pkg::CODE_POS_W'(slot) * fvp_pkg::CODE_POS_W'(fvp_pkg::WIDTH_CODE_W);
        tab_word   = width_table_reg[tab_sel];
        width_code = tab_word[code_pos +: fvp_pkg::WIDTH_CODE_W];
        width_sum  = fvp_pkg::CODE_POS_W'(width_code) + fvp_pkg::CODE_POS_W'(1);
        if (width_sum > fvp_pkg::CODE_POS_W'(VALUE_BITS))
            width_sat = fvp_pkg::CODE_POS_W'(VALUE_BITS);
        else
            width_sat = width_sum;
    end

    // offset removal and masking
    always_comb
    begin
        push_width = W_W'(width_sat);
        diff       = field_value[VALUE_BITS-1:0] - VALUE_BITS'(value_offset_reg);
        value_mask = ~({VALUE_BITS{1'b1}} << push_width);
        push_value = diff & value_mask;
        push_last  = last_field;
    end

    // handshake toward the queue
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push       = in_valid && push_ready;

    // field position within the record
    always_comb
    begin
        field_index_next = field_index_reg;
        if (push)
            field_index_next = last_field ? '0 : field_index_reg + IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            field_index_reg <= '0;
        else
            field_index_reg <= field_index_next;
    end

endmodule

// File: rtl/fvp_queue.sv
module fvp_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    // depth must stay a power of two so the pointers wrap on their own
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              wr_en;
    logic              rd_en;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + CNT_W'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= in_data;
    end

    // fill level never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill level beyond depth");

endmodule

// File: rtl/fvp_back.sv
module fvp_back #(
    parameter int VALUE_BITS = fvp_pkg::VALUE_BITS_DEF,
    localparam int W_W = $clog2(VALUE_BITS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  logic [VALUE_BITS-1:0]       pop_value,
    input  logic [W_W-1:0]              pop_width,
    input  logic                        pop_last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [fvp_pkg::BYTE_W-1:0]  packed_byte,
    output logic                        record_end
);

    localparam int ACC_W = VALUE_BITS + fvp_pkg::PEND_W;
    localparam int TOT_W = $clog2(ACC_W + 1);
    localparam int PW    = fvp_pkg::PEND_W;
    localparam int PCW   = fvp_pkg::PEND_CNT_W;
    localparam int BW    = fvp_pkg::BYTE_W;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [TOT_W-1:0] total_reg;
    logic [TOT_W-1:0] total_next;
    logic             last_reg;
    logic             last_next;
    logic             busy_reg;
    logic             busy_next;
    logic [PW-1:0]    pending_bits_reg;
    logic [PW-1:0]    pending_bits_next;
    logic [PCW-1:0]   pending_count_reg;
    logic [PCW-1:0]   pending_count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [BW-1:0]    packed_byte_reg;
    logic             record_end_reg;

    logic             done_quiet;
    logic             idle_now;
    logic [PW-1:0]    pend_bits_eff;
    logic [PCW-1:0]   pend_cnt_eff;
    logic             take;
    logic [ACC_W-1:0] fresh_acc;
    logic [TOT_W-1:0] fresh_total;
    logic [ACC_W-1:0] cur_acc;
    logic [TOT_W-1:0] cur_total;
    logic             cur_last;
    logic             cur_active;
    logic             has_full;
    logic             out_free;
    logic             emit;
    logic             record_done;

    // a word with fewer than eight bits left and no record end just parks its bits
    always_comb
    begin
        done_quiet    = busy_reg && (total_reg < TOT_W'(BW)) && !last_reg;
        idle_now      = !busy_reg || done_quiet;
        pend_bits_eff = done_quiet ? acc_reg[PW-1:0] : pending_bits_reg;
        pend_cnt_eff  = done_quiet ? total_reg[PCW-1:0] : pending_count_reg;
        take          = idle_now && pop_valid;
        fresh_acc     = ACC_W'(pend_bits_eff) | (ACC_W'(pop_value) << pend_cnt_eff);
        fresh_total   = TOT_W'(pend_cnt_eff) + TOT_W'(pop_width);
    end

    // working word: fresh from the queue or carried over
    always_comb
    begin
        cur_acc    = take ? fresh_acc : acc_reg;
        cur_total  = take ? fresh_total : total_reg;
        cur_last   = take ? pop_last : last_reg;
        cur_active = take || (busy_reg && !done_quiet);
        has_full   = (cur_total >= TOT_W'(BW));
        out_free   = !out_valid_reg || out_ready;
        emit       = cur_active && (has_full || cur_last) && out_free;
        record_done = emit && cur_last && (cur_total <= TOT_W'(BW));
    end

    assign pop_ready = idle_now;

    // next state of the bit accumulator
    always_comb
    begin
        acc_next           = acc_reg;
        total_next         = total_reg;
        last_next          = last_reg;
        busy_next          = busy_reg;
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        if (idle_now)
        begin
            pending_bits_next  = pend_bits_eff;
            pending_count_next = pend_cnt_eff;
            busy_next          = 1'b0;
        end
        if (cur_active)
        begin
            if (record_done)
            begin
                busy_next          = 1'b0;
                pending_bits_next  = '0;
                pending_count_next = '0;
            end
            else if (emit)
            begin
                busy_next  = 1'b1;
                acc_next   = cur_acc >> BW;
                total_next = cur_total - TOT_W'(BW);
                last_next  = cur_last;
            end
            else if (!has_full && !cur_last)
            begin
                busy_next          = 1'b0;
                pending_bits_next  = cur_acc[PW-1:0];
                pending_count_next = cur_total[PCW-1:0];
            end
            else
            begin
                busy_next  = 1'b1;
                acc_next   = cur_acc;
                total_next = cur_total;
                last_next  = cur_last;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b0;
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            busy_reg          <= busy_next;
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // accumulator and output payload
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        total_reg <= total_next;
        last_reg  <= last_next;
        if (emit)
        begin
            packed_byte_reg <= cur_acc[BW-1:0];
            record_end_reg  <= record_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign packed_byte = packed_byte_reg;
    assign record_end  = record_end_reg;

    // while busy, bits above the live count are clear
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((acc_reg >> total_reg) == '0))
        else $error("accumulator holds stray bits above its count");

    // the record end leaves no pending bits behind
    assert property (@(posedge clk) disable iff (!rst_n)
        record_done |=> (pending_count_reg == '0) && (pending_bits_reg == '0))
        else $error("pending bits survive a record end");

    // a new word is only taken once the current one is retired
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (total_reg >= TOT_W'(BW))) |-> !pop_ready)
        else $error("queue popped while bytes remain");

endmodule

// File: rtl/variable_width_field_packer_top.sv
// Packs a record of field values into an lsb-first byte stream. Each accepted word on the
// input is one field: the offset register is subtracted (wrapping), the result is cut to
// that field's width from the width tables (code plus one, 1 to 32 bits), and the bits are
// appended behind any bits still pending. Full bytes leave at one byte per cycle while the
// output is not stalled; after the last field of a record a partial byte is flushed
// zero-padded, and the final byte of the record carries record_end. The back end takes a
// new field only once the current one has no full byte left, or for a record's last field,
// no bits left. A two-entry queue between the classifying front and the packing back end
// lets the input keep taking fields while bytes drain, and the output is registered. The
// user must write the configuration registers only while the block is idle; the block
// itself does not enforce this.
module variable_width_field_packer_top #(
    parameter int MAX_FIELDS = fvp_pkg::MAX_FIELDS_DEF,
    parameter int VALUE_BITS = fvp_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fvp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fvp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fvp_pkg::FIELD_VALUE_W-1:0] field_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fvp_pkg::BYTE_W-1:0]        packed_byte,
    output logic                              record_end
);

    localparam int W_W    = $clog2(VALUE_BITS + 1);
    localparam int WORD_W = VALUE_BITS + W_W + 1;

    logic                  push_valid;
    logic                  push_ready;
    logic [VALUE_BITS-1:0] push_value;
    logic [W_W-1:0]        push_width;
    logic                  push_last;
    logic                  pop_valid;
    logic                  pop_ready;
    logic [WORD_W-1:0]     pop_word;

    // field classification and width lookup
    fvp_front #(
        .MAX_FIELDS (MAX_FIELDS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .field_value (field_value),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_value  (push_value),
        .push_width  (push_width),
        .push_last   (push_last)
    );

    // decoupling queue
    fvp_queue #(
        .DATA_W (WORD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_last, push_width, push_value}),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_word)
    );

    // bit packing and byte output
    fvp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_value   (pop_word[VALUE_BITS-1:0]),
        .pop_width   (pop_word[VALUE_BITS +: W_W]),
        .pop_last    (pop_word[WORD_W-1]),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .packed_byte (packed_byte),
        .record_end  (record_end)
    );

endmodule
